/* sv/gtrt_pkg.sv */
`default_nettype none

package gtrt_pkg;

	// slot table size
	localparam int SLOTS = 8;
	localparam logic [SLOTS-1:0] SLOT_LSB = SLOTS'(1);

	// queue between front and back, depth is a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam logic [QPTR_W:0] QCOUNT_FULL = (QPTR_W + 1)'(QDEPTH);

	localparam int TAG_W = 32;

	// operation codes on the request channel
	localparam logic [2:0] OP_ISSUE    = 3'd0;
	localparam logic [2:0] OP_SENT     = 3'd1;
	localparam logic [2:0] OP_COMPLETE = 3'd2;
	localparam logic [2:0] OP_QUERY    = 3'd3;
	localparam logic [2:0] OP_RELEASE  = 3'd4;

	typedef struct packed {
		logic [2:0]       operation;
		logic [TAG_W-1:0] tag;
	} req_item_t;

	typedef struct packed {
		logic [TAG_W-1:0] issued_tag;
		logic             done_flag;
	} rsp_item_t;

	// classified command, nop covers unused codes and tag zero on non-issue ops
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_ISSUE,
		CMD_SENT,
		CMD_COMPLETE,
		CMD_QUERY,
		CMD_RELEASE
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [TAG_W-1:0] tag;
	} cmd_item_t;

	typedef struct packed {
		logic      valid;
		cmd_item_t item;
	} cmd_chan_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

endpackage

`default_nettype wire

/* sv/gtrt_front.sv */
`default_nettype none

module gtrt_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  gtrt_pkg::req_item_t  req,
	output gtrt_pkg::cmd_chan_t  push,
	input  wire                  q_full
);

	logic                fr_valid_q;
	gtrt_pkg::cmd_item_t fr_item_q;
	gtrt_pkg::cmd_item_t cls;
	logic                tag_zero;

	assign tag_zero = (req.tag == '0);

	// decode the operation, tag zero turns a tagged op into a nop
	always_comb begin
		cls.tag = req.tag;
		unique case (req.operation)
			gtrt_pkg::OP_ISSUE:    cls.cmd = gtrt_pkg::CMD_ISSUE;
			gtrt_pkg::OP_SENT:     cls.cmd = tag_zero ? gtrt_pkg::CMD_NOP : gtrt_pkg::CMD_SENT;
			gtrt_pkg::OP_COMPLETE: cls.cmd = tag_zero ? gtrt_pkg::CMD_NOP
			                                          : gtrt_pkg::CMD_COMPLETE;
			gtrt_pkg::OP_QUERY:    cls.cmd = tag_zero ? gtrt_pkg::CMD_NOP : gtrt_pkg::CMD_QUERY;
			gtrt_pkg::OP_RELEASE:  cls.cmd = tag_zero ? gtrt_pkg::CMD_NOP
			                                          : gtrt_pkg::CMD_RELEASE;
			default:               cls.cmd = gtrt_pkg::CMD_NOP;
		endcase
	end

	assign req_stall  = fr_valid_q && q_full;
	assign push.valid = fr_valid_q && !q_full;
	assign push.item  = fr_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else if (!req_stall) begin
			fr_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			fr_item_q <= cls;
		end
	end

endmodule

`default_nettype wire

/* sv/gtrt_queue.sv */
`default_nettype none

module gtrt_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  gtrt_pkg::cmd_chan_t  push,
	output logic                 full,
	output gtrt_pkg::cmd_chan_t  head,
	input  wire                  pop
);

	gtrt_pkg::cmd_item_t          mem [gtrt_pkg::QDEPTH];
	logic [gtrt_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [gtrt_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [gtrt_pkg::QPTR_W:0]    count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full       = (count_q == gtrt_pkg::QCOUNT_FULL);
	assign head.valid = (count_q != '0);
	assign head.item  = mem[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.item;
		end
	end

endmodule

`default_nettype wire

/* sv/gtrt_back.sv */
`default_nettype none

module gtrt_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  gtrt_pkg::cmd_chan_t  head,
	output logic                 pop,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output gtrt_pkg::rsp_item_t  rsp
);

	gtrt_pkg::bk_state_t             state_q;
	gtrt_pkg::bk_state_t             state_nxt;
	logic                            fire;

	logic [gtrt_pkg::TAG_W-1:0]      slot_tag_q [gtrt_pkg::SLOTS];
	logic [gtrt_pkg::SLOTS-1:0]      slot_sent_q;
	logic [gtrt_pkg::SLOTS-1:0]      slot_done_q;
	logic [gtrt_pkg::TAG_W-1:0]      tag_ctr_q;

	gtrt_pkg::cmd_t                  cmd_q;
	logic [gtrt_pkg::SLOTS-1:0]      match_q;
	logic [gtrt_pkg::SLOTS-1:0]      match;
	logic [gtrt_pkg::SLOTS-1:0]      hit;
	logic                            any_hit;
	logic [gtrt_pkg::TAG_W-1:0]      ctr_inc;
	logic [gtrt_pkg::TAG_W-1:0]      new_tag;

	logic                            rsp_valid_q;
	gtrt_pkg::rsp_item_t             rsp_q;
	gtrt_pkg::rsp_item_t             result;

	// qualifying slots for the item at the queue head
	always_comb begin
		for (int i = 0; i < gtrt_pkg::SLOTS; i++) begin
			unique case (head.item.cmd)
				gtrt_pkg::CMD_ISSUE:    match[i] = (slot_tag_q[i] == '0);
				gtrt_pkg::CMD_COMPLETE: match[i] = (slot_tag_q[i] == head.item.tag) &&
				                                   slot_sent_q[i];
				gtrt_pkg::CMD_SENT,
				gtrt_pkg::CMD_QUERY,
				gtrt_pkg::CMD_RELEASE:  match[i] = (slot_tag_q[i] == head.item.tag);
				default:                match[i] = 1'b0;
			endcase
		end
	end

	// lowest qualifying slot as a one-hot vector
	assign hit     = match_q & (~match_q + gtrt_pkg::SLOT_LSB);
	assign any_hit = |match_q;

	// wrapping counter that skips zero
	assign ctr_inc = tag_ctr_q + 1'b1;
	assign new_tag = (ctr_inc == '0) ? {{(gtrt_pkg::TAG_W-1){1'b0}}, 1'b1} : ctr_inc;

	always_comb begin
		result.issued_tag = '0;
		result.done_flag  = 1'b0;
		if (cmd_q == gtrt_pkg::CMD_ISSUE && any_hit) begin
			result.issued_tag = new_tag;
		end
		if (cmd_q == gtrt_pkg::CMD_QUERY) begin
			result.done_flag = |(hit & slot_done_q);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gtrt_pkg::BK_IDLE: if (head.valid) state_nxt = gtrt_pkg::BK_EXEC;
			gtrt_pkg::BK_EXEC: if (!rsp_valid_q || !rsp_stall) state_nxt = gtrt_pkg::BK_IDLE;
			default:           state_nxt = gtrt_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		fire = 1'b0;
		unique case (state_q)
			gtrt_pkg::BK_IDLE: pop  = head.valid;
			gtrt_pkg::BK_EXEC: fire = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gtrt_pkg::BK_IDLE;
			rsp_valid_q <= 1'b0;
			tag_ctr_q   <= '0;
			slot_sent_q <= '0;
			slot_done_q <= '0;
			for (int i = 0; i < gtrt_pkg::SLOTS; i++) begin
				slot_tag_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (fire && cmd_q == gtrt_pkg::CMD_ISSUE && any_hit) begin
				tag_ctr_q <= new_tag;
			end
			for (int i = 0; i < gtrt_pkg::SLOTS; i++) begin
				if (fire && hit[i]) begin
					case (cmd_q)
						gtrt_pkg::CMD_ISSUE: begin
							slot_tag_q[i]  <= new_tag;
							slot_sent_q[i] <= 1'b0;
							slot_done_q[i] <= 1'b0;
						end
						gtrt_pkg::CMD_SENT:     slot_sent_q[i] <= 1'b1;
						gtrt_pkg::CMD_COMPLETE: slot_done_q[i] <= 1'b1;
						gtrt_pkg::CMD_RELEASE: begin
							slot_tag_q[i]  <= '0;
							slot_sent_q[i] <= 1'b0;
							slot_done_q[i] <= 1'b0;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= head.item.cmd;
			match_q <= match;
		end
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* sv/generation_tagged_response_tracker.sv */
`default_nettype none

// channel   valid      stall      item
// request   req_valid  req_stall  req (operation, tag)
// response  rsp_valid  rsp_stall  rsp (issued_tag, done_flag)
//
// the back end takes each item through an idle state, where the tag compare over
// all slots is registered as the item is popped, then an exec state, where the
// lowest-slot pick, table update and response write follow, before the next pop
// reset frees every slot, clears all flags, zeroes the tag counter, empties the queue
// req_stall rises only when the front register and the 2-entry queue are both full
// rsp_stall holds the response register, and the back end waits on it

module generation_tagged_response_tracker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  gtrt_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output gtrt_pkg::rsp_item_t  rsp
);

	// front to queue
	gtrt_pkg::cmd_chan_t push;
	logic                q_full;

	// queue to back
	gtrt_pkg::cmd_chan_t head;
	logic                pop;

	// front: registers the request; unused codes and zero-tag non-issue ops become a nop
	gtrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.q_full    (q_full)
	);

	// short queue so the front keeps taking items while the back works
	gtrt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// back: slot table, tag counter and response register
	gtrt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
